[src/tlgr_pkg.sv]
// Shared constants and types for the text line glyph renderer.
// Depends on nothing; the font ROM and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package tlgr_pkg;

	// Default line length in display columns.
	localparam int LINE_COLUMNS_DEF = 128;

	// Columns taken by one character: five glyph columns and one blank spacer.
	localparam int GLYPH_COLS = 5;
	localparam int CHAR_PITCH = 6;

	// A line never spans more than this many 64-bit words.
	localparam int WORD_CAP   = 16;
	localparam int WORD_BYTES = 8;

	// Width of the pending byte buffer (one byte short of a full word).
	localparam int PEND_BYTES = WORD_BYTES - 1;

	typedef logic [7:0]                  col_byte_t;
	typedef logic [GLYPH_COLS*8-1:0]     glyph_t;
	typedef logic [WORD_BYTES*8-1:0]     word_t;
	typedef logic [PEND_BYTES*8-1:0]     pend_t;
	typedef logic [$clog2(WORD_BYTES)-1:0] pend_cnt_t;

endpackage

`default_nettype wire

[src/tlgr_font_rom.sv]
// 5x8 font lookup for space, digits and both letter cases.
// Depends on tlgr_pkg for the glyph type; unlisted codes give a blank glyph.
`timescale 1ns / 1ps
`default_nettype none

module tlgr_font_rom
	import tlgr_pkg::*;
(
	input  wire logic [7:0] char_code,
	output glyph_t          glyph
);

	localparam logic [7:0] CODE_ZERO    = 8'h30;
	localparam logic [7:0] CODE_NINE    = 8'h39;
	localparam logic [7:0] CODE_UPPER_A = 8'h41;
	localparam logic [7:0] CODE_UPPER_Z = 8'h5A;
	localparam logic [7:0] CODE_LOWER_A = 8'h61;
	localparam logic [7:0] CODE_LOWER_Z = 8'h7A;

	// Column bytes per glyph, leftmost column first, bit 0 is the top pixel.
	localparam col_byte_t DIGIT_ROM [10][GLYPH_COLS] = '{
		'{8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E}, '{8'h00, 8'h21, 8'h7F, 8'h01, 8'h00},
		'{8'h23, 8'h45, 8'h49, 8'h49, 8'h31}, '{8'h22, 8'h41, 8'h49, 8'h49, 8'h36},
		'{8'h0C, 8'h14, 8'h24, 8'h7F, 8'h04}, '{8'h72, 8'h51, 8'h51, 8'h51, 8'h4E},
		'{8'h1E, 8'h29, 8'h49, 8'h49, 8'h06}, '{8'h40, 8'h47, 8'h48, 8'h50, 8'h60},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C}
	};

	localparam col_byte_t UPPER_ROM [26][GLYPH_COLS] = '{
		'{8'h3E, 8'h09, 8'h09, 8'h09, 8'h3E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
		'{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
		'{8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
		'{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
		'{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
		'{8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
		'{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
		'{8'h26, 8'h49, 8'h49, 8'h49, 8'h32}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
		'{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
		'{8'h7F, 8'h20, 8'h10, 8'h20, 8'h7F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
		'{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
	};

	localparam col_byte_t LOWER_ROM [26][GLYPH_COLS] = '{
		'{8'h20, 8'h54, 8'h54, 8'h54, 8'h78}, '{8'h7F, 8'h48, 8'h44, 8'h44, 8'h38},
		'{8'h38, 8'h44, 8'h44, 8'h44, 8'h20}, '{8'h38, 8'h44, 8'h44, 8'h48, 8'h7F},
		'{8'h38, 8'h54, 8'h54, 8'h54, 8'h18}, '{8'h08, 8'h7E, 8'h09, 8'h01, 8'h02},
		'{8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E}, '{8'h7F, 8'h08, 8'h04, 8'h04, 8'h78},
		'{8'h00, 8'h44, 8'h7D, 8'h40, 8'h00}, '{8'h20, 8'h40, 8'h44, 8'h3D, 8'h00},
		'{8'h7F, 8'h10, 8'h28, 8'h44, 8'h00}, '{8'h00, 8'h41, 8'h7F, 8'h40, 8'h00},
		'{8'h7C, 8'h04, 8'h18, 8'h04, 8'h78}, '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h78},
		'{8'h38, 8'h44, 8'h44, 8'h44, 8'h38}, '{8'h7C, 8'h14, 8'h14, 8'h14, 8'h08},
		'{8'h08, 8'h14, 8'h14, 8'h14, 8'h7C}, '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h08},
		'{8'h48, 8'h54, 8'h54, 8'h54, 8'h20}, '{8'h04, 8'h3F, 8'h44, 8'h40, 8'h20},
		'{8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C}, '{8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C},
		'{8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C}, '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
		'{8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C}, '{8'h44, 8'h64, 8'h54, 8'h4C, 8'h44}
	};

	logic [7:0] digit_off;
	logic [7:0] upper_off;
	logic [7:0] lower_off;

	assign digit_off = char_code - CODE_ZERO;
	assign upper_off = char_code - CODE_UPPER_A;
	assign lower_off = char_code - CODE_LOWER_A;

	// Pick the glyph table by code range and pack the columns low byte first.
	always_comb begin
		glyph = '0;
		for (int i = 0; i < GLYPH_COLS; i++) begin
			if (char_code >= CODE_ZERO && char_code <= CODE_NINE) begin
				glyph[8*i +: 8] = DIGIT_ROM[digit_off[3:0]][i];
			end else if (char_code >= CODE_UPPER_A && char_code <= CODE_UPPER_Z) begin
				glyph[8*i +: 8] = UPPER_ROM[upper_off[4:0]][i];
			end else if (char_code >= CODE_LOWER_A && char_code <= CODE_LOWER_Z) begin
				glyph[8*i +: 8] = LOWER_ROM[lower_off[4:0]][i];
			end
		end
	end

endmodule

`default_nettype wire

[src/text_line_glyph_renderer.sv]
// Top level of the text line glyph renderer: input register, packing logic,
// end-of-line flush sequencing and the output word register.
// Depends on tlgr_pkg and tlgr_font_rom.
//
// Characters are rendered into 6-column cells (5 glyph columns and a blank
// spacer) and packed little-endian into 64-bit words, leftmost column in the
// lowest byte. A character item yields at most one word; items beyond the
// line capacity are dropped. An end item flushes the partly filled word and
// zero padding up to the line length, one word per cycle while the output is
// not stalled, and flags the final word with last. The input is stalled
// during the flush until its final word is taken into the output register,
// and in any cycle in which a word is due but the output is stalled.
// An end item with no character before it produces no output.
`timescale 1ns / 1ps
`default_nettype none

module text_line_glyph_renderer
	import tlgr_pkg::*;
#(
	parameter int LINE_COLUMNS = LINE_COLUMNS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  char_code,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      column_word,
	output logic [3:0]       word_index,
	output logic             last
);

	localparam int WORDS_RAW   = (LINE_COLUMNS + WORD_BYTES - 1) / WORD_BYTES;
	localparam int LINE_WORDS  = (WORDS_RAW < WORD_CAP) ? WORDS_RAW : WORD_CAP;
	localparam int USABLE_COLS = (LINE_COLUMNS < LINE_WORDS * WORD_BYTES) ?
		LINE_COLUMNS : LINE_WORDS * WORD_BYTES;
	localparam int CHAR_LIMIT  = USABLE_COLS / CHAR_PITCH;
	localparam int WORDS_W     = $clog2(LINE_WORDS + 1);
	localparam int CHARS_W     = $clog2(CHAR_LIMIT + 1);
	localparam int MERGE_W     = (PEND_BYTES + CHAR_PITCH) * 8;
	localparam int SUM_W       = $clog2(PEND_BYTES + CHAR_PITCH + 1);

	// Input register.
	logic        v_s1;
	logic        kind_s1;
	logic [7:0]  code_s1;

	// Line state.
	pend_t                pend_q;
	pend_cnt_t            pend_cnt_q;
	logic [WORDS_W-1:0]   words_sent_q;
	logic [CHARS_W-1:0]   chars_q;
	logic                 seen_q;

	// Output register.
	logic                 out_valid_q;
	word_t                word_q;
	logic [3:0]           index_q;
	logic                 last_q;

	glyph_t               glyph;
	logic [MERGE_W-1:0]   merged;
	logic [SUM_W-1:0]     cnt_sum;
	logic                 out_free;
	logic                 char_room;
	logic                 word_full;
	logic                 line_open;
	logic                 final_word;
	logic                 emit;
	logic                 adv;

	tlgr_font_rom u_font (
		.char_code (code_s1),
		.glyph     (glyph)
	);

	// Append the new cell (glyph plus blank spacer) after the pending bytes.
	assign merged = {{CHAR_PITCH{8'h00}}, pend_q} |
		({{(PEND_BYTES + 1){8'h00}}, glyph} << {pend_cnt_q, 3'b000});
	assign cnt_sum    = SUM_W'(pend_cnt_q) + SUM_W'(CHAR_PITCH);
	assign word_full  = cnt_sum >= SUM_W'(WORD_BYTES);
	assign char_room  = chars_q < CHARS_W'(CHAR_LIMIT);
	assign line_open  = words_sent_q < WORDS_W'(LINE_WORDS);
	assign final_word = words_sent_q == WORDS_W'(LINE_WORDS - 1);
	assign out_free   = !out_valid_q || !out_stall;

	// Decide whether the held item produces a word this cycle and whether it retires.
	always_comb begin
		emit = 1'b0;
		adv  = 1'b0;
		if (v_s1) begin
			if (!kind_s1) begin
				if (char_room && word_full && line_open) begin
					emit = out_free;
					adv  = out_free;
				end else begin
					adv = 1'b1;
				end
			end else if (!seen_q || !line_open) begin
				adv = 1'b1;
			end else begin
				emit = out_free;
				adv  = out_free && final_word;
			end
		end
	end

	assign in_stall = v_s1 && !adv;

	// Input register: take a new word whenever the held one retires or none is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			code_s1 <= char_code;
		end
	end

	// Line state update for character and end items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			pend_cnt_q   <= '0;
			words_sent_q <= '0;
			chars_q      <= '0;
			seen_q       <= 1'b0;
		end else if (v_s1 && !kind_s1) begin
			seen_q <= 1'b1;
			if (char_room && (!word_full || !line_open || out_free)) begin
				chars_q <= chars_q + 1'b1;
				if (word_full) begin
					pend_q     <= pend_t'(merged[MERGE_W-1:WORD_BYTES*8]);
					pend_cnt_q <= pend_cnt_t'(cnt_sum - SUM_W'(WORD_BYTES));
					if (line_open) begin
						words_sent_q <= words_sent_q + 1'b1;
					end
				end else begin
					pend_q     <= merged[PEND_BYTES*8-1:0];
					pend_cnt_q <= pend_cnt_t'(cnt_sum);
				end
			end
		end else if (v_s1 && seen_q) begin
			if (!line_open || (out_free && final_word)) begin
				pend_q       <= '0;
				pend_cnt_q   <= '0;
				words_sent_q <= '0;
				chars_q      <= '0;
				seen_q       <= 1'b0;
			end else if (out_free) begin
				pend_q       <= '0;
				pend_cnt_q   <= '0;
				words_sent_q <= words_sent_q + 1'b1;
			end
		end
	end

	// Output register: holds a word until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q  <= kind_s1 ? word_t'(pend_q) : merged[WORD_BYTES*8-1:0];
			index_q <= 4'(words_sent_q);
			last_q  <= final_word;
		end
	end

	assign out_valid   = out_valid_q;
	assign column_word = word_q;
	assign word_index  = index_q;
	assign last        = last_q;

endmodule

`default_nettype wire

[tb/tb_text_line_glyph_renderer.sv]
// Self-checking testbench for text_line_glyph_renderer: drives character and end words,
// predicts the packed column words from its own font table and compares them in order.
// Depends on tlgr_pkg and the text_line_glyph_renderer RTL.
`timescale 1ns / 1ps

module tb_text_line_glyph_renderer;
	import tlgr_pkg::*;

	// Word kinds on the input side.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Character codes that bound the font ranges.
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	// Line geometry for the default line length.
	localparam int WORDS_RAW  = (LINE_COLUMNS_DEF + 7) / 8;
	localparam int LINE_WORDS = (WORDS_RAW < WORD_CAP) ? WORDS_RAW : WORD_CAP;
	localparam int USABLE     = (LINE_COLUMNS_DEF < LINE_WORDS * 8) ?
		LINE_COLUMNS_DEF : LINE_WORDS * 8;
	localparam int CHAR_LIMIT = USABLE / CHAR_PITCH;

	localparam int RANDOM_ITEMS = 430;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 24;

	// Font glyphs: the leftmost column sits in the top byte of each entry.
	localparam glyph_t DIGIT_FONT [10] = '{
		40'h3E4549513E, 40'h00217F0100, 40'h2345494931, 40'h2241494936,
		40'h0C14247F04, 40'h725151514E, 40'h1E29494906, 40'h4047485060,
		40'h3649494936, 40'h3049494A3C
	};
	localparam glyph_t UPPER_FONT [26] = '{
		40'h3E0909093E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
		40'h7F49494941, 40'h7F09090901, 40'h3E4149493A, 40'h7F0808087F,
		40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
		40'h3E4151215E, 40'h7F09192946, 40'h2649494932, 40'h01017F0101,
		40'h3F4040403F, 40'h1F2040201F, 40'h7F2010207F, 40'h6314081463,
		40'h0708700807, 40'h6151494543
	};
	localparam glyph_t LOWER_FONT [26] = '{
		40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F,
		40'h3854545418, 40'h087E090102, 40'h0C5252523E, 40'h7F08040478,
		40'h00447D4000, 40'h2040443D00, 40'h7F10284400, 40'h00417F4000,
		40'h7C04180478, 40'h7C08040478, 40'h3844444438, 40'h7C14141408,
		40'h081414147C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
		40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844,
		40'h0C5050503C, 40'h4464544C44
	};

	typedef struct {
		word_t      cols;
		logic [3:0] idx;
		logic       fin;
	} column_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] column_word;
	logic [3:0]  word_index;
	logic        last;

	// Predicted line state.
	word_t line_cols;
	int    line_fill;
	int    line_words;
	int    line_chars;
	bit    line_open;

	column_word_t words_due[$];
	int errors;
	int items_sent;
	int lines_done;
	int words_checked;
	int quiet_cycles;
	bit steady;

	text_line_glyph_renderer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.column_word(column_word),
		.word_index (word_index),
		.last       (last)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Font lookup; codes outside the table render blank.
	function automatic glyph_t glyph_of(input logic [7:0] code);
		if (code >= CH_ZERO && code <= CH_NINE)
			return DIGIT_FONT[code - CH_ZERO];
		if (code >= CH_UPPER_A && code <= CH_UPPER_Z)
			return UPPER_FONT[code - CH_UPPER_A];
		if (code >= CH_LOWER_A && code <= CH_LOWER_Z)
			return LOWER_FONT[code - CH_LOWER_A];
		return '0;
	endfunction

	// Queue the packed word and start a fresh one.
	task automatic emit_word();
		column_word_t w;
		w.cols = line_cols;
		w.idx  = line_words[3:0];
		w.fin  = (line_words + 1 == LINE_WORDS);
		words_due.push_back(w);
		line_words++;
		line_cols = '0;
		line_fill = 0;
	endtask

	// Append one column byte; a full word goes out unless the line is already complete.
	task automatic push_column(input logic [7:0] b);
		line_cols[8*line_fill +: 8] = b;
		line_fill++;
		if (line_fill == WORD_BYTES) begin
			if (line_words < LINE_WORDS) begin
				emit_word();
			end else begin
				line_cols = '0;
				line_fill = 0;
			end
		end
	endtask

	// Work out the column words that one accepted input word causes.
	task automatic render_item(input logic k, input logic [7:0] code);
		glyph_t g;
		if (k == KIND_CHAR) begin
			line_open = 1'b1;
			if (line_chars < CHAR_LIMIT) begin
				line_chars++;
				g = glyph_of(code);
				for (int i = 0; i < GLYPH_COLS; i++)
					push_column(g[39 - 8*i -: 8]);
				push_column(8'h00);
			end
		end else if (line_open) begin
			while (line_words < LINE_WORDS)
				emit_word();
			line_cols  = '0;
			line_fill  = 0;
			line_words = 0;
			line_chars = 0;
			line_open  = 1'b0;
			lines_done++;
		end
	endtask

	// Send one input word, with an occasional idle gap first.
	task automatic send_item(input logic k, input logic [7:0] code);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 20)
			gap = $urandom_range(1, 2);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		kind      <= k;
		char_code <= code;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		render_item(k, code);
		items_sent++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_words_due();
		while (words_due.size() != 0)
			@(posedge clk);
	endtask

	// Mostly font characters, sometimes any byte at all.
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return CH_UPPER_A + 8'($urandom_range(0, 25));
		if (r < 6)
			return CH_LOWER_A + 8'($urandom_range(0, 25));
		if (r == 6)
			return CH_ZERO + 8'($urandom_range(0, 9));
		if (r == 7)
			return CH_SPACE;
		return 8'($urandom_range(0, 255));
	endfunction

	// An end word on an empty line must produce nothing.
	task automatic test_empty_end();
		send_item(KIND_END, 8'hFF);
		release_input();
		wait_words_due();
	endtask

	// Short line flushed with padding, then a second end that finds the line empty.
	task automatic test_short_line();
		send_item(KIND_CHAR, CH_UPPER_A);
		send_item(KIND_CHAR, CH_LOWER_Z);
		send_item(KIND_END, 8'h00);
		send_item(KIND_END, 8'h5A);
		release_input();
		wait_words_due();
	endtask

	// Range edges and blank codes, one more character than the line holds.
	task automatic test_overflow_line();
		logic [7:0] codes [22];
		codes = '{8'h00, 8'hFF, CH_SPACE, CH_ZERO, CH_NINE, CH_UPPER_A, CH_UPPER_Z,
			CH_LOWER_A, CH_LOWER_Z, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B,
			8'h7F, 8'h80, 8'h55, 8'hAA, 8'h4D, 8'h6D, 8'h35};
		foreach (codes[i])
			send_item(KIND_CHAR, codes[i]);
		send_item(KIND_END, 8'hAA);
		release_input();
		wait_words_due();
	endtask

	// Random lines of random length, with an idle-free stretch and one full drain.
	task automatic test_random_lines();
		int sent;
		int nline;
		int len;
		int r;
		sent  = 0;
		nline = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (nline >= 20 && nline < 30);
			if (nline == 15) begin
				release_input();
				wait_words_due();
			end
			r = $urandom_range(0, 99);
			if (r < 8)
				len = 0;
			else if (r < 20)
				len = $urandom_range(CHAR_LIMIT, CHAR_LIMIT + 6);
			else
				len = $urandom_range(1, CHAR_LIMIT - 1);
			for (int i = 0; i < len; i++)
				send_item(KIND_CHAR, pick_char());
			send_item(KIND_END, 8'($urandom_range(0, 255)));
			sent += len + 1;
			nline++;
		end
		steady = 1'b0;
		release_input();
	endtask

	// Receiver stalls at random except during the steady stretch.
	always @(negedge clk) begin
		out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 20);
	end

	// Compare each accepted column word with the oldest prediction; watch for a hang.
	always @(posedge clk) begin : check_words
		column_word_t w;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (out_valid && !out_stall) begin
			if (words_due.size() == 0) begin
				$error("column word %h with no prediction waiting", column_word);
				errors++;
			end else begin
				w = words_due.pop_front();
				words_checked++;
				if (column_word !== w.cols) begin
					$error("column_word: expected %h, got %h", w.cols, column_word);
					errors++;
				end
				if (word_index !== w.idx) begin
					$error("word_index: expected %0d, got %0d", w.idx, word_index);
					errors++;
				end
				if (last !== w.fin) begin
					$error("last: expected %0b, got %0b", w.fin, last);
					errors++;
				end
			end
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timed out with %0d column words outstanding.", words_due.size());
			$display("FAIL text_line_glyph_renderer");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_CHAR;
		char_code     = 8'h00;
		out_stall     = 1'b0;
		steady        = 1'b0;
		errors        = 0;
		items_sent    = 0;
		lines_done    = 0;
		words_checked = 0;
		quiet_cycles  = 0;
		line_cols     = '0;
		line_fill     = 0;
		line_words    = 0;
		line_chars    = 0;
		line_open     = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_end();
		test_short_line();
		test_overflow_line();
		test_random_lines();

		wait_words_due();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d input words over %0d rendered lines, including empty and overfull lines.",
			items_sent, lines_done);
		$display("Checked %0d column words under random idle and stall on both sides.",
			words_checked);
		if (errors == 0)
			$display("PASS text_line_glyph_renderer");
		else
			$display("FAIL text_line_glyph_renderer");
		$finish;
	end

endmodule

[sim.f]
src/tlgr_pkg.sv
src/tlgr_font_rom.sv
src/text_line_glyph_renderer.sv
tb/tb_text_line_glyph_renderer.sv
